[src/hslrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hslrgb_pkg
// Shared widths, hue breakpoints and the hue ramp helper of the HSL to RGB
// converter.
// ----------------------------------------------------------------------------
package hslrgb_pkg;

  localparam int unsigned COMP_W = 16;   // hue, lightness, saturation, rgb
  localparam int unsigned POS_W  = 18;   // hue position in 1/196608 turn
  localparam int unsigned FRAC_W = 16;   // ramp weight, 0 .. 32768
  localparam int unsigned QW     = 32;   // q, p, q - p in Q0.32
  localparam int unsigned PROD_W = QW + FRAC_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned NCH    = 3;

  // channel order inside the lane arrays
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  localparam logic [POS_W-1:0] TURN_POS       = 18'd196608;
  localparam logic [POS_W-1:0] THIRD_POS      = 18'd65536;
  localparam logic [POS_W-1:0] SIXTH_POS      = 18'd32768;
  localparam logic [POS_W-1:0] HALF_POS       = 18'd98304;
  localparam logic [POS_W-1:0] TWO_THIRDS_POS = 18'd131072;

  localparam logic [FRAC_W-1:0] FRAC_FULL  = 16'd32768;
  localparam logic [FRAC_W-1:0] FRAC_ZERO  = 16'd0;
  localparam logic [COMP_W-1:0] HALF_LEVEL = 16'd32768;
  localparam logic [COMP_W-1:0] COMP_MAX   = 16'hFFFF;
  localparam logic [SUM_W-1:0]  ROUND_HALF = 49'h0_0000_4000_0000; // 2^30

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [QW-1:0]     qval_t;
  typedef logic [PROD_W-1:0] prod_t;

  // Weight of (q - p) in the ramp: result = p*32768 + (q - p)*weight.
  function automatic frac_t ramp_frac(input pos_t t);
    pos_t diff;
    diff = TWO_THIRDS_POS - t;
    if (t < SIXTH_POS) begin
      return t[FRAC_W-1:0];
    end else if (t < HALF_POS) begin
      return FRAC_FULL;
    end else if (t < TWO_THIRDS_POS) begin
      return diff[FRAC_W-1:0];
    end else begin
      return FRAC_ZERO;
    end
  endfunction

endpackage

[src/hsl_to_rgb_converter.sv]
// Path: an accepted input beat passes the 3 pipe stages and then the output
//   register before it becomes its output beat.
// Throughput: one beat per cycle while out_stall is low; the three 32x16 ramp multipliers in stage 3
//   and the 16x16 lightness*saturation multiplier in stage 1 each take a beat
//   every cycle. Bubbles collapse on stall.
// Reset: rst_n (sync, active low) clears all stage valid bits; data regs keep.
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// Pipelined HSL to RGB conversion, Q0.16 in and out, rounded and saturated.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter
  import hslrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_hue,
  input  logic [15:0] in_lightness,
  input  logic [15:0] in_saturation,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue
);

  // per-stage advance
  logic rdy1, rdy2, rdy3, rdy_out;

  // stage 1: L*S, ramp weights
  logic                    v1_r;
  comp_t                   lig1_r, sat1_r;
  logic                    grey1_r;
  qval_t                   ls1_r;
  logic [NCH-1:0][FRAC_W-1:0] f1_r;

  // stage 2: x, where p = L*2^16 - x and q - p = 2x
  logic                    v2_r;
  comp_t                   lig2_r;
  logic                    grey2_r;
  qval_t                   x2_r;
  logic [NCH-1:0][FRAC_W-1:0] f2_r;

  // stage 3: p and the three products
  logic                    v3_r;
  comp_t                   lig3_r;
  logic                    grey3_r;
  qval_t                   p3_r;
  logic [NCH-1:0][PROD_W-1:0] prod3_r;

  // output register
  logic                    out_valid_r;
  logic [NCH-1:0][COMP_W-1:0] rgb_r;

  // combinational next values
  pos_t                    th;
  pos_t                    t_red_raw;
  logic [NCH-1:0][POS_W-1:0] t_nxt;
  logic [NCH-1:0][FRAC_W-1:0] f1_nxt;
  qval_t                   ls_nxt;
  qval_t                   x2_nxt;
  qval_t                   p3_nxt;
  qval_t                   d2;
  logic [NCH-1:0][PROD_W-1:0] prod3_nxt;
  logic [NCH-1:0][SUM_W-1:0]  sum;
  logic [NCH-1:0][COMP_W-1:0] rgb_nxt;

  always_comb begin
    rdy_out  = !out_valid_r || !out_stall;
    rdy3     = !v3_r || rdy_out;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    in_stall = !rdy1;
  end

  // ---- stage 1 logic ----
  always_comb begin
    th        = {1'b0, in_hue, 1'b0} + {2'b00, in_hue};
    t_red_raw = th + THIRD_POS;
    t_nxt[CH_GREEN] = th;
    t_nxt[CH_RED]   = (t_red_raw >= TURN_POS) ? (t_red_raw - TURN_POS) : t_red_raw;
    t_nxt[CH_BLUE]  = (th < THIRD_POS) ? (th + TWO_THIRDS_POS) : (th - THIRD_POS);
    for (int c = 0; c < NCH; c++) begin
      f1_nxt[c] = ramp_frac(t_nxt[c]);
    end
    ls_nxt = {16'h0000, in_lightness} * {16'h0000, in_saturation};
  end

  // ---- stage 2 logic ----
  always_comb begin
    if (lig1_r < HALF_LEVEL) begin
      x2_nxt = ls1_r;
    end else begin
      x2_nxt = {sat1_r, 16'h0000} - ls1_r;
    end
  end

  // ---- stage 3 logic ----
  always_comb begin
    d2     = {x2_r[QW-2:0], 1'b0};
    p3_nxt = {lig2_r, 16'h0000} - x2_r;
    for (int c = 0; c < NCH; c++) begin
      prod3_nxt[c] = {16'h0000, d2} * {32'h0000_0000, f2_r[c]};
    end
  end

  // ---- output logic: add p*32768, round half up, saturate; grey beats take lightness ----
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      sum[c] = {2'b00, p3_r, 15'h0000} + {1'b0, prod3_r[c]} + ROUND_HALF;
      if (grey3_r) begin
        rgb_nxt[c] = lig3_r;
      end else if (sum[c][SUM_W-1:SUM_W-2] != 2'b00) begin
        rgb_nxt[c] = COMP_MAX;
      end else begin
        rgb_nxt[c] = sum[c][SUM_W-3:31];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      lig1_r  <= in_lightness;
      sat1_r  <= in_saturation;
      grey1_r <= (in_saturation == '0);
      ls1_r   <= ls_nxt;
      f1_r    <= f1_nxt;
    end
    if (rdy2) begin
      lig2_r  <= lig1_r;
      grey2_r <= grey1_r;
      x2_r    <= x2_nxt;
      f2_r    <= f1_r;
    end
    if (rdy3) begin
      lig3_r  <= lig2_r;
      grey3_r <= grey2_r;
      p3_r    <= p3_nxt;
      prod3_r <= prod3_nxt;
    end
    if (rdy_out) begin
      rgb_r <= rgb_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = rgb_r[CH_RED];
  assign out_green = rgb_r[CH_GREEN];
  assign out_blue  = rgb_r[CH_BLUE];

endmodule

[src/hslrgb_checker.sv]
// ----------------------------------------------------------------------------
// hslrgb_checker
// Port-level checks of the HSL to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hslrgb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_lightness,
  input logic [15:0] in_saturation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_red,
  input logic [15:0] out_green,
  input logic [15:0] out_blue
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled output beat changed");

  // input backpressure only comes from a full, stalled pipe
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output is moving");

  // grey beat, with out_stall low while it passes the stages, shows up as lightness on all three channels
  a_grey_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_saturation == 16'd0
      ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid && out_red == $past(in_lightness, 4)
        && out_green == $past(in_lightness, 4) && out_blue == $past(in_lightness, 4))
    else $error("grey beat wrong or late");

endmodule

bind hsl_to_rgb_converter hslrgb_checker u_hslrgb_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_lightness (in_lightness),
  .in_saturation(in_saturation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_red      (out_red),
  .out_green    (out_green),
  .out_blue     (out_blue)
);
